// ----- sv/iso7816_slave_register_block_defines.svh -----
// Assertion macros for the smart-card slave register block.
// Used by the modules that carry concurrent checks; expects clock and reset in scope.
`ifndef ISO7816_SLAVE_REGISTER_BLOCK_DEFINES_SVH
`define ISO7816_SLAVE_REGISTER_BLOCK_DEFINES_SVH

// same-cycle implication, off during reset
`define ISOSLV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ISOSLV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/isoslv_pkg.sv -----
// Shared types, register map, reset values and write masks of the slave register block.
// No dependencies.
package isoslv_pkg;

   localparam int REG_COUNT_DEF = 25;
   localparam int ADDR_W = 7;
   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;
   localparam int FUNC_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd2;

   localparam logic [ADDR_W-1:0] A_CON      = 7'h00;
   localparam logic [ADDR_W-1:0] A_CON1     = 7'h04;
   localparam logic [ADDR_W-1:0] A_CON2     = 7'h08;
   localparam logic [ADDR_W-1:0] A_STS      = 7'h0C;
   localparam logic [ADDR_W-1:0] A_BRC      = 7'h10;
   localparam logic [ADDR_W-1:0] A_BUF      = 7'h14;
   localparam logic [ADDR_W-1:0] A_DIO      = 7'h18;
   localparam logic [ADDR_W-1:0] A_MSK      = 7'h1C;
   localparam logic [ADDR_W-1:0] A_DMACON   = 7'h30;
   localparam logic [ADDR_W-1:0] A_DMASTS   = 7'h34;
   localparam logic [ADDR_W-1:0] A_DMABFAD  = 7'h38;
   localparam logic [ADDR_W-1:0] A_DMABFLEN = 7'h3C;
   localparam logic [ADDR_W-1:0] A_DMAMSK   = 7'h44;
   localparam logic [ADDR_W-1:0] A_TCON     = 7'h50;
   localparam logic [ADDR_W-1:0] A_TDAT     = 7'h54;
   localparam logic [ADDR_W-1:0] A_TRLD     = 7'h58;
   localparam logic [ADDR_W-1:0] A_TMSK     = 7'h5C;
   localparam logic [ADDR_W-1:0] A_NULL     = 7'h60;

   localparam int CON_IDX = 0;
   localparam int STS_IDX = 3;
   localparam int BUF_IDX = 5;
   localparam int MSK_IDX = 7;

   localparam int CON_TR_BIT   = 5;
   localparam int CON_TACT_BIT = 4;
   localparam int STS_RBF_BIT  = 1;
   localparam int STS_PE_BIT   = 2;
   localparam int STS_OE_BIT   = 3;

   typedef struct packed {
      logic              valid;
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] bus_address;
      logic [DATA_W-1:0] write_data;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] read_data;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_taken;
      logic              irq;
   } rsp_type;

   function automatic logic [DATA_W-1:0] reg_reset(input logic [ADDR_W-1:0] addr);
      logic [DATA_W-1:0] v;
      unique case (addr)
         A_CON, A_STS, A_BRC, A_DIO, A_TMSK: v = 32'h0000_0001;
         A_CON1, A_DMAMSK:                   v = 32'h0000_0007;
         A_NULL:                             v = 32'h0000_0060;
         default:                            v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [DATA_W-1:0] wmask(input logic [ADDR_W-1:0] addr);
      logic [DATA_W-1:0] m;
      unique case (addr)
         A_CON:               m = 32'h0000_00A0;
         A_CON1:              m = 32'h0000_003F;
         A_CON2:              m = 32'h0000_0085;
         A_MSK:               m = 32'h0000_008F;
         A_BRC, A_BUF:        m = 32'h0000_00FF;
         A_DIO, A_DMACON:     m = 32'h0000_0003;
         A_DMASTS, A_DMAMSK:  m = 32'h0000_0007;
         A_DMABFAD:           m = 32'h00FF_FFFF;
         A_DMABFLEN:          m = 32'h0000_01FF;
         A_TCON:              m = 32'h0000_000F;
         A_TMSK:              m = 32'h0000_0001;
         A_TDAT, A_TRLD:      m = 32'h0000_FFFF;
         A_NULL:              m = 32'h0000_00FF;
         default:             m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- sv/isoslv_req_stage.sv -----
// Input register of the slave register block: captures each accepted request.
// Depends on isoslv_pkg.
module isoslv_req_stage
   import isoslv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [FUNC_W-1:0] func,
   input  logic [ADDR_W-1:0] bus_address,
   input  logic [DATA_W-1:0] write_data,
   input  logic [BYTE_W-1:0] rx_byte,
   output req_type           req
);

   logic    valid_ff, valid_in;
   req_type req_ff, req_in;

   always_comb begin
      valid_in           = accept;
      req_in.valid       = 1'b0;
      req_in.func        = func;
      req_in.bus_address = bus_address;
      req_in.write_data  = write_data;
      req_in.rx_byte     = rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         req_ff <= req_in;
      end
   end

   always_comb begin
      req       = req_ff;
      req.valid = valid_ff;
   end

endmodule

// ----- sv/isoslv_regs.sv -----
// Register file with single-pass update logic and the result register.
// Depends on isoslv_pkg and iso7816_slave_register_block_defines.svh.
`include "iso7816_slave_register_block_defines.svh"

module isoslv_regs
   import isoslv_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   output rsp_type rsp
);

   localparam int IDX_W = $clog2(REG_COUNT);

   logic [DATA_W-1:0] rf_ff [REG_COUNT];
   logic [DATA_W-1:0] rf_in [REG_COUNT];
   logic              valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [4:0]        word;
   logic [IDX_W-1:0]  idx;
   logic              ok;
   logic [DATA_W-1:0] m;

   always_comb begin
      word = req.bus_address[ADDR_W-1:2];
      idx  = word[IDX_W-1:0];
      ok   = (req.bus_address[1:0] == 2'b00) && (32'(word) < REG_COUNT);
      m    = wmask(req.bus_address);

      rf_in            = rf_ff;
      rsp_in.valid     = 1'b0;
      rsp_in.read_data = '0;
      rsp_in.tx_valid  = 1'b0;
      rsp_in.tx_byte   = '0;
      rsp_in.rx_taken  = 1'b0;

      if (req.valid) begin
         unique case (req.func)
            FUNC_READ: begin
               if (ok) begin
                  rsp_in.read_data = rf_ff[idx];
                  if (req.bus_address == A_BUF) begin
                     rf_in[STS_IDX][STS_RBF_BIT] = 1'b0;
                  end
               end
            end
            FUNC_WRITE: begin
               if (ok) begin
                  priority if (req.bus_address == A_STS) begin
                     rf_in[STS_IDX][STS_PE_BIT] = rf_ff[STS_IDX][STS_PE_BIT] &
                                                  ~req.write_data[STS_PE_BIT];
                     rf_in[STS_IDX][STS_OE_BIT] = rf_ff[STS_IDX][STS_OE_BIT] &
                                                  ~req.write_data[STS_OE_BIT];
                  end else if (req.bus_address == A_BUF && rf_ff[CON_IDX][CON_TR_BIT]) begin
                     rsp_in.tx_valid               = 1'b1;
                     rsp_in.tx_byte                = req.write_data[BYTE_W-1:0];
                     rf_in[CON_IDX][CON_TACT_BIT]  = 1'b0;
                  end else begin
                     rf_in[idx] = (rf_ff[idx] & ~m) | (req.write_data & m);
                  end
               end
            end
            FUNC_RX: begin
               if (!rf_ff[CON_IDX][CON_TR_BIT]) begin
                  rsp_in.rx_taken = 1'b1;
                  if (rf_ff[STS_IDX][STS_RBF_BIT]) begin
                     rf_in[STS_IDX][STS_OE_BIT] = 1'b1;
                  end else begin
                     rf_in[STS_IDX][STS_RBF_BIT] = 1'b1;
                  end
                  rf_in[BUF_IDX] = DATA_W'(req.rx_byte);
               end
            end
            default: begin
            end
         endcase
      end

      rsp_in.irq = |(rf_in[STS_IDX] & rf_in[MSK_IDX]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= reg_reset(ADDR_W'(i * 4));
         end
      end else begin
         valid_ff <= req.valid;
         rf_ff    <= rf_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp       = rsp_ff;
      rsp.valid = valid_ff;
   end

   `ISOSLV_ASSERT_NEXT(a_rsp_follows_req, req.valid, valid_ff,
      "accepted request produced no result")
   `ISOSLV_ASSERT_NOW(a_tx_rx_exclusive, valid_ff, !(rsp_ff.tx_valid && rsp_ff.rx_taken),
      "transmit and receive in one result")
   `ISOSLV_ASSERT_NOW(a_tx_needs_tr, valid_ff && rsp_ff.tx_valid,
      $past(rf_ff[CON_IDX][CON_TR_BIT]), "transmit while not in transmit mode")
   `ISOSLV_ASSERT_NOW(a_oe_needs_rbf, $rose(rf_ff[STS_IDX][STS_OE_BIT]),
      $past(rf_ff[STS_IDX][STS_RBF_BIT]), "overrun set without full buffer")

endmodule

// ----- sv/iso7816_slave_register_block.sv -----
// Smart-card slave UART register file: bus read, bus write or received byte, one request per
// cycle. busy stays low, so a request is taken at every cycle with start high. Each request
// gives exactly one result on rsp_valid; the path is an input register, one pass of masked
// update logic, and a result register. The receiver cannot stall, so results must be taken
// in the cycle they appear.
module iso7816_slave_register_block
   import isoslv_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ADDR_W-1:0] req_bus_address,
   input  logic [DATA_W-1:0] req_write_data,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_tx_valid,
   output logic [BYTE_W-1:0] rsp_tx_byte,
   output logic              rsp_rx_taken,
   output logic              rsp_irq
);

   req_type req;
   rsp_type rsp;

   assign busy = 1'b0;

   isoslv_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .accept      (start && !busy),
      .func        (req_func),
      .bus_address (req_bus_address),
      .write_data  (req_write_data),
      .rx_byte     (req_rx_byte),
      .req         (req)
   );

   isoslv_regs #(
      .REG_COUNT (REG_COUNT)
   ) u_regs (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   assign rsp_valid     = rsp.valid;
   assign rsp_read_data = rsp.read_data;
   assign rsp_tx_valid  = rsp.tx_valid;
   assign rsp_tx_byte   = rsp.tx_byte;
   assign rsp_rx_taken  = rsp.rx_taken;
   assign rsp_irq       = rsp.irq;

endmodule
